>>> rtl/core/pwd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polygon winding detect package
// Shared widths, default parameters and orientation codes.
// ----------------------------------------------------------------------------
package pwd_pkg;

    // Default coordinate and vertex counter widths
    localparam int COORD_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF = 16;

    // Fixed field widths
    localparam int THRESH_BITS    = 16;
    localparam int INDEX_BITS     = 16;
    localparam int ORIENT_BITS    = 2;

    // Smallest contour (closing vertex included) that gets evaluated
    localparam int MIN_POINTS     = 3;

    // Result word: clockwise, orientation, lowest_index, padded to bytes
    localparam int RESULT_BITS    = 1 + ORIENT_BITS + INDEX_BITS;
    localparam int RESULT_DATA_W  = ((RESULT_BITS + 7) / 8) * 8;

    typedef enum logic [ORIENT_BITS-1:0] {
        ORIENT_CCW       = 2'd0,
        ORIENT_CW        = 2'd1,
        ORIENT_COLLINEAR = 2'd2,
        ORIENT_NOT_EVAL  = 2'd3
    } orient_t;

endpackage

>>> rtl/core/polygon_winding_detect_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polygon winding detect
// Tracks the lowest vertex of a streamed contour with its neighbors and
// classifies the cross product at that vertex on the closing vertex.
// ----------------------------------------------------------------------------
// The closing vertex loads the difference register, then the product and
// result registers. Throughput: one vertex word per cycle unless the result
// stream stalls; the vertex search is one compare and register update, the
// cross product runs in a three-stage pipeline.
// Reset: rst_n clears the contour state, the pipeline valids and the
// threshold register (to zero); the block is ready right after reset.
module polygon_winding_detect_top #(
    parameter int COORD_BITS = pwd_pkg::COORD_BITS_DEF,
    parameter int COUNT_BITS = pwd_pkg::COUNT_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,

    // Configuration: collinear_threshold
    input  logic                                   cfg_wr_en,
    input  logic [pwd_pkg::THRESH_BITS-1:0]        cfg_wr_data,

    // Vertex stream
    // tdata: point_x, point_y (from bit 0 up), zero padded to bytes
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
    input  logic                                   s_axis_tlast,   // last_point
    input  logic                                   s_axis_tuser,   // path_closed

    // Result stream
    // tdata: clockwise, orientation, lowest_index (from bit 0 up), zero padded
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [pwd_pkg::RESULT_DATA_W-1:0]      m_axis_tdata
);

    localparam int W1   = COORD_BITS + 1;
    localparam int PW   = 2 * W1;
    localparam int VW   = PW + 1;
    localparam int LW   = (COUNT_BITS > pwd_pkg::INDEX_BITS) ? COUNT_BITS
                                                             : pwd_pkg::INDEX_BITS;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_EVAL = COUNT_BITS'(pwd_pkg::MIN_POINTS - 1);

    // ------------------------------------------------------------------
    // Handshake: the whole pipeline moves when the result register frees
    // ------------------------------------------------------------------
    logic advance;
    logic in_accept;
    logic m_valid_reg;

    assign advance       = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;
    assign in_accept     = s_axis_tvalid && advance;

    // Unpack the vertex word
    logic signed [COORD_BITS-1:0] pt_x;
    logic signed [COORD_BITS-1:0] pt_y;

    assign pt_x = s_axis_tdata[COORD_BITS-1:0];
    assign pt_y = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];

    // ------------------------------------------------------------------
    // Threshold register
    // ------------------------------------------------------------------
    logic [pwd_pkg::THRESH_BITS-1:0] thresh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            thresh_reg <= cfg_wr_data;
        end
    end

    // ------------------------------------------------------------------
    // Contour tracking state
    // ------------------------------------------------------------------
    logic signed [COORD_BITS-1:0] first_x_reg,  first_x_next;
    logic signed [COORD_BITS-1:0] first_y_reg,  first_y_next;
    logic signed [COORD_BITS-1:0] prev_x_reg,   prev_x_next;
    logic signed [COORD_BITS-1:0] prev_y_reg,   prev_y_next;
    logic signed [COORD_BITS-1:0] low_x_reg,    low_x_next;
    logic signed [COORD_BITS-1:0] low_y_reg,    low_y_next;
    logic signed [COORD_BITS-1:0] bef_x_reg,    bef_x_next;
    logic signed [COORD_BITS-1:0] bef_y_reg,    bef_y_next;
    logic signed [COORD_BITS-1:0] aft_x_reg,    aft_x_next;
    logic signed [COORD_BITS-1:0] aft_y_reg,    aft_y_next;
    logic [COUNT_BITS-1:0]        low_pos_reg,  low_pos_next;
    logic                         await_reg,    await_next;
    logic [COUNT_BITS-1:0]        count_reg,    count_next;

    logic is_first;
    logic new_lowest;

    assign is_first   = (count_reg == '0);
    assign new_lowest = is_first || (pt_y < low_y_reg) ||
                        ((pt_y == low_y_reg) && (pt_x < low_x_reg));

    // Update the search on a vertex word, clear it on the closing word
    always_comb
    begin
        first_x_next = first_x_reg;
        first_y_next = first_y_reg;
        prev_x_next  = prev_x_reg;
        prev_y_next  = prev_y_reg;
        low_x_next   = low_x_reg;
        low_y_next   = low_y_reg;
        bef_x_next   = bef_x_reg;
        bef_y_next   = bef_y_reg;
        aft_x_next   = aft_x_reg;
        aft_y_next   = aft_y_reg;
        low_pos_next = low_pos_reg;
        await_next   = await_reg;
        count_next   = count_reg;

        if (in_accept)
        begin
            if (s_axis_tlast)
            begin
                first_x_next = '0;
                first_y_next = '0;
                prev_x_next  = '0;
                prev_y_next  = '0;
                low_x_next   = '0;
                low_y_next   = '0;
                bef_x_next   = '0;
                bef_y_next   = '0;
                aft_x_next   = '0;
                aft_y_next   = '0;
                low_pos_next = '0;
                await_next   = 1'b0;
                count_next   = '0;
            end
            else
            begin
                if (new_lowest)
                begin
                    low_x_next   = pt_x;
                    low_y_next   = pt_y;
                    low_pos_next = count_reg;
                    bef_x_next   = prev_x_reg;
                    bef_y_next   = prev_y_reg;
                    await_next   = 1'b1;
                end
                else if (await_reg)
                begin
                    aft_x_next = pt_x;
                    aft_y_next = pt_y;
                    await_next = 1'b0;
                end
                if (is_first)
                begin
                    first_x_next = pt_x;
                    first_y_next = pt_y;
                end
                prev_x_next = pt_x;
                prev_y_next = pt_y;
                if (count_reg != CNT_MAX)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_x_reg <= '0;
            first_y_reg <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            low_x_reg   <= '0;
            low_y_reg   <= '0;
            bef_x_reg   <= '0;
            bef_y_reg   <= '0;
            aft_x_reg   <= '0;
            aft_y_reg   <= '0;
            low_pos_reg <= '0;
            await_reg   <= 1'b0;
            count_reg   <= '0;
        end
        else
        begin
            first_x_reg <= first_x_next;
            first_y_reg <= first_y_next;
            prev_x_reg  <= prev_x_next;
            prev_y_reg  <= prev_y_next;
            low_x_reg   <= low_x_next;
            low_y_reg   <= low_y_next;
            bef_x_reg   <= bef_x_next;
            bef_y_reg   <= bef_y_next;
            aft_x_reg   <= aft_x_next;
            aft_y_reg   <= aft_y_next;
            low_pos_reg <= low_pos_next;
            await_reg   <= await_next;
            count_reg   <= count_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: pick neighbors with wrap-around, form the differences
    // ------------------------------------------------------------------
    logic signed [COORD_BITS-1:0] nb_px, nb_py, nb_nx, nb_ny;

    // Predecessor wraps to the last searched vertex, successor to the first
    assign nb_px = (low_pos_reg == '0) ? prev_x_reg : bef_x_reg;
    assign nb_py = (low_pos_reg == '0) ? prev_y_reg : bef_y_reg;
    assign nb_nx = await_reg ? first_x_reg : aft_x_reg;
    assign nb_ny = await_reg ? first_y_reg : aft_y_reg;

    logic                         s1_valid_reg;
    logic                         s1_eval_reg;
    logic [COUNT_BITS-1:0]        s1_pos_reg;
    logic [pwd_pkg::THRESH_BITS-1:0] s1_thresh_reg;
    logic signed [W1-1:0]         s1_dx1_reg, s1_dy1_reg, s1_dy2_reg, s1_dx2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_accept && s_axis_tlast;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_eval_reg   <= s_axis_tuser && (count_reg >= CNT_EVAL);
            s1_pos_reg    <= low_pos_reg;
            s1_thresh_reg <= thresh_reg;
            s1_dx1_reg    <= W1'(low_x_reg) - W1'(nb_px);
            s1_dy1_reg    <= W1'(low_y_reg) - W1'(nb_ny);
            s1_dy2_reg    <= W1'(nb_py) - W1'(low_y_reg);
            s1_dx2_reg    <= W1'(nb_nx) - W1'(low_x_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: the two products of the cross product
    // ------------------------------------------------------------------
    logic                         s2_valid_reg;
    logic                         s2_eval_reg;
    logic [COUNT_BITS-1:0]        s2_pos_reg;
    logic [pwd_pkg::THRESH_BITS-1:0] s2_thresh_reg;
    logic signed [PW-1:0]         s2_prod_a_reg, s2_prod_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_eval_reg   <= s1_eval_reg;
            s2_pos_reg    <= s1_pos_reg;
            s2_thresh_reg <= s1_thresh_reg;
            s2_prod_a_reg <= s1_dx1_reg * s1_dy1_reg;
            s2_prod_b_reg <= s1_dy2_reg * s1_dx2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: subtract, classify against the threshold band
    // ------------------------------------------------------------------
    logic signed [VW-1:0] cross_v;
    logic signed [VW-1:0] thr_pos;
    logic signed [VW-1:0] thr_neg;
    pwd_pkg::orient_t     orient;

    assign cross_v = VW'(s2_prod_a_reg) - VW'(s2_prod_b_reg);
    assign thr_pos = VW'($signed({1'b0, s2_thresh_reg}));
    assign thr_neg = -thr_pos;

    always_comb
    begin
        if (!s2_eval_reg)
        begin
            orient = pwd_pkg::ORIENT_NOT_EVAL;
        end
        else if (cross_v > thr_pos)
        begin
            orient = pwd_pkg::ORIENT_CCW;
        end
        else if (cross_v < thr_neg)
        begin
            orient = pwd_pkg::ORIENT_CW;
        end
        else
        begin
            orient = pwd_pkg::ORIENT_COLLINEAR;
        end
    end

    logic [LW-1:0] pos_ext;

    assign pos_ext = LW'(s2_pos_reg);

    // Result register
    logic                                 cw_reg;
    pwd_pkg::orient_t                     orient_reg;
    logic [pwd_pkg::INDEX_BITS-1:0]       index_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            m_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cw_reg     <= (orient == pwd_pkg::ORIENT_CW);
            orient_reg <= orient;
            index_reg  <= pos_ext[pwd_pkg::INDEX_BITS-1:0];
        end
    end

    // Drive the result word
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = pwd_pkg::RESULT_DATA_W'({index_reg, orient_reg, cw_reg});

endmodule
